// ----- rtl/core/mfqs_pkg.sv -----
// Package with the beat types and event and status codes of the feedback queue scheduler.
package mfqs_pkg;

    typedef enum logic [2:0] {
        FUNC_NEW     = 3'd0,
        FUNC_BLOCK   = 3'd1,
        FUNC_END     = 3'd2,
        FUNC_UNBLOCK = 3'd3,
        FUNC_TIMER   = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_ENDED   = 2'd3
    } status_t;

    localparam int TID_W = 4;
    localparam int LIVE_W = 5;
    localparam logic [LIVE_W-1:0] LIVE_MAX = 5'd31;

    typedef struct packed {
        logic [2:0]       func;
        logic [TID_W-1:0] thread_id;
    } req_t;

    typedef struct packed {
        logic             switched;
        logic [TID_W-1:0] old_thread;
        logic [TID_W-1:0] next_thread;
        logic             idle;
    } rsp_t;

endpackage

// ----- rtl/core/multilevel_feedback_queue_scheduler_top.sv -----
// Top level of the multilevel feedback queue scheduler.
//
// The scheduler takes one event beat on the req channel (func, thread_id) and
// returns exactly one result beat on the rsp channel (switched, old_thread,
// next_thread, idle). Both channels use a valid/ready handshake.
// New threads enter the level 0 queue; unblocked and preempted threads enter
// one level below the current level, and block, end and a timer tick on the
// running thread dispatch the head of the highest non-empty level.
// The queue entries live in one synchronous memory indexed by {level, slot},
// and the per-level head, tail and count live in a second synchronous memory
// with a valid bit per level, so no clearing pass is needed after reset.
// Events are handled one at a time by a sequencer that reads, modifies and
// writes back these memories. An enqueue passes through the push state and a
// dispatch through the search, descriptor pop and data pop states; the result
// register is loaded in the done state once the previous result has been taken,
// and the next event can be accepted after that.
// The result register decouples the sides: a stalled receiver holds the
// result, and the next event is accepted as soon as the sequencer is free.
// Reset (rst_n low) empties all levels, marks all threads ready, sets the
// running thread and current level to zero and the live count to one.
module multilevel_feedback_queue_scheduler_top
    import mfqs_pkg::*;
#(
    parameter int NUM_THREADS = 16,
    parameter int NUM_LEVELS  = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int PTR_W  = (NUM_THREADS > 2) ? $clog2(NUM_THREADS) : 1;
    localparam int CNT_W  = $clog2(NUM_THREADS + 1);
    localparam int LVL_W  = (NUM_LEVELS > 2) ? $clog2(NUM_LEVELS) : 1;
    localparam int DEPTH  = NUM_LEVELS << PTR_W;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_THREADS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_THREADS);
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(NUM_LEVELS - 1);

    // Per-level queue descriptor.
    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [CNT_W-1:0] count;
    } desc_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SEARCH,
        S_POP_DESC,
        S_POP_DATA,
        S_DONE
    } state_t;

    state_t state_reg;

    // Memories.
    logic [TID_W-1:0] fifo_mem [DEPTH];
    desc_t            desc_mem [NUM_LEVELS];

    logic [TID_W-1:0] fifo_q_reg;
    desc_t            desc_q_reg;

    // Control state.
    logic [NUM_LEVELS-1:0] desc_vld_reg;
    logic [NUM_LEVELS-1:0] nonempty_reg;
    status_t               status_reg [NUM_THREADS];
    logic [LVL_W-1:0]      cur_lvl_reg;
    logic [LIVE_W-1:0]     live_reg;
    logic [TID_W-1:0]      running_reg;

    // Working registers of the event in flight.
    logic [LVL_W-1:0]  work_lvl_reg;
    logic [TID_W-1:0]  work_tid_reg;
    logic              need_sw_reg;
    rsp_t              res_reg;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;

    // Event decode in the accept cycle.
    logic              accept;
    logic              tid_ok;
    logic [PTR_W+5:0]  tid_idx_w;
    logic [$clog2(NUM_THREADS)-1:0] tid_idx;
    logic              ev_new;
    logic              ev_block;
    logic              ev_end;
    logic              ev_unblock;
    logic              ev_timer_run;
    logic              do_push;
    logic              need_sw;
    logic              stay;
    logic [LVL_W-1:0]  demote_lvl;
    logic [LVL_W-1:0]  push_lvl;

    // Queue update signals.
    desc_t             desc_cur;
    logic              push_ok;
    logic [PTR_W-1:0]  tail_next;
    logic [PTR_W-1:0]  head_next;
    logic [CNT_W-1:0]  cnt_dec;
    logic              found;
    logic [LVL_W-1:0]  found_lvl;
    logic              nxt_ok;
    logic [$clog2(NUM_THREADS)-1:0] nxt_idx;
    logic [PTR_W+5:0]  nxt_idx_w;

    logic              desc_re;
    logic [LVL_W-1:0]  desc_raddr;
    logic              desc_we;
    desc_t             desc_wdata;
    logic              fifo_re;
    logic              fifo_we;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Thread ids beyond the thread count leave the state untouched.
    assign tid_ok    = ({{(PTR_W+2){1'b0}}, req.thread_id} < (PTR_W+6)'(NUM_THREADS));
    assign tid_idx_w = {{(PTR_W+2){1'b0}}, req.thread_id};
    assign tid_idx   = tid_idx_w[$clog2(NUM_THREADS)-1:0];

    always_comb
    begin
        ev_new       = tid_ok && (req.func == FUNC_NEW);
        ev_block     = tid_ok && (req.func == FUNC_BLOCK);
        ev_end       = tid_ok && (req.func == FUNC_END);
        ev_unblock   = tid_ok && (req.func == FUNC_UNBLOCK);
        ev_timer_run = tid_ok && (req.func == FUNC_TIMER)
                       && (status_reg[tid_idx] == ST_RUNNING);
        do_push      = ev_new || ev_unblock || ev_timer_run;
        need_sw      = ev_block || ev_end || ev_timer_run;
        // A preempted thread stays at its level when it is the only live one.
        stay         = ev_timer_run && (live_reg == LIVE_W'(1));
        if (stay || (cur_lvl_reg == LVL_LAST))
        begin
            demote_lvl = cur_lvl_reg;
        end
        else
        begin
            demote_lvl = cur_lvl_reg + 1'b1;
        end
        push_lvl = ev_new ? '0 : demote_lvl;
    end

    // A level whose descriptor was never written reads as an empty queue.
    assign desc_cur  = desc_vld_reg[work_lvl_reg] ? desc_q_reg : '0;
    assign push_ok   = (desc_cur.count != CNT_FULL);
    assign tail_next = (desc_cur.tail == PTR_LAST) ? '0 : desc_cur.tail + 1'b1;
    assign head_next = (desc_cur.head == PTR_LAST) ? '0 : desc_cur.head + 1'b1;
    assign cnt_dec   = desc_cur.count - 1'b1;

    // Highest-priority non-empty level.
    always_comb
    begin
        found     = 1'b0;
        found_lvl = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                found     = 1'b1;
                found_lvl = LVL_W'(i);
            end
        end
    end

    assign nxt_idx_w = {{(PTR_W+2){1'b0}}, fifo_q_reg};
    assign nxt_idx   = nxt_idx_w[$clog2(NUM_THREADS)-1:0];
    assign nxt_ok    = (nxt_idx_w < (PTR_W+6)'(NUM_THREADS));

    // Memory port control.
    always_comb
    begin
        desc_re     = 1'b0;
        desc_raddr  = push_lvl;
        desc_we     = 1'b0;
        desc_wdata  = desc_cur;
        fifo_re     = 1'b0;
        fifo_we     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                desc_re    = accept && do_push;
                desc_raddr = push_lvl;
            end
            S_PUSH:
            begin
                fifo_we          = push_ok;
                desc_we          = push_ok;
                desc_wdata.tail  = tail_next;
                desc_wdata.count = desc_cur.count + 1'b1;
            end
            S_SEARCH:
            begin
                desc_re    = found;
                desc_raddr = found_lvl;
            end
            S_POP_DESC:
            begin
                fifo_re          = 1'b1;
                desc_we          = 1'b1;
                desc_wdata.head  = head_next;
                desc_wdata.count = cnt_dec;
            end
            S_POP_DATA,
            S_DONE:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (desc_we)
        begin
            desc_mem[work_lvl_reg] <= desc_wdata;
        end
        if (desc_re)
        begin
            desc_q_reg <= desc_mem[desc_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[{work_lvl_reg, desc_cur.tail}] <= work_tid_reg;
        end
        if (fifo_re)
        begin
            fifo_q_reg <= fifo_mem[{work_lvl_reg, desc_cur.head}];
        end
    end

    // Sequencer, scheduler state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            desc_vld_reg  <= '0;
            nonempty_reg  <= '0;
            for (int i = 0; i < NUM_THREADS; i++)
            begin
                status_reg[i] <= ST_READY;
            end
            cur_lvl_reg   <= '0;
            live_reg      <= LIVE_W'(1);
            running_reg   <= '0;
            need_sw_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // In the done state the result register is reloaded below instead.
            if (rsp_valid_reg && rsp_ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        work_lvl_reg         <= push_lvl;
                        work_tid_reg         <= req.thread_id;
                        need_sw_reg          <= need_sw;
                        res_reg.switched     <= 1'b0;
                        res_reg.old_thread   <= running_reg;
                        res_reg.next_thread  <= '0;
                        res_reg.idle         <= 1'b0;
                        if (ev_new || ev_unblock || ev_timer_run)
                        begin
                            status_reg[tid_idx] <= ST_READY;
                        end
                        else if (ev_block)
                        begin
                            status_reg[tid_idx] <= ST_BLOCKED;
                        end
                        else if (ev_end)
                        begin
                            status_reg[tid_idx] <= ST_ENDED;
                        end
                        if (ev_new && (live_reg != LIVE_MAX))
                        begin
                            live_reg <= live_reg + 1'b1;
                        end
                        else if (ev_end && (live_reg != '0))
                        begin
                            live_reg <= live_reg - 1'b1;
                        end
                        if (do_push)
                        begin
                            state_reg <= S_PUSH;
                        end
                        else if (need_sw)
                        begin
                            state_reg <= S_SEARCH;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_PUSH:
                begin
                    // A full level drops the enqueue.
                    if (push_ok)
                    begin
                        desc_vld_reg[work_lvl_reg] <= 1'b1;
                        nonempty_reg[work_lvl_reg] <= 1'b1;
                    end
                    state_reg <= need_sw_reg ? S_SEARCH : S_DONE;
                end
                S_SEARCH:
                begin
                    if (found)
                    begin
                        work_lvl_reg <= found_lvl;
                        state_reg    <= S_POP_DESC;
                    end
                    else
                    begin
                        res_reg.idle <= 1'b1;
                        state_reg    <= S_DONE;
                    end
                end
                S_POP_DESC:
                begin
                    nonempty_reg[work_lvl_reg] <= (cnt_dec != '0);
                    state_reg                  <= S_POP_DATA;
                end
                S_POP_DATA:
                begin
                    res_reg.switched    <= 1'b1;
                    res_reg.next_thread <= fifo_q_reg;
                    running_reg         <= fifo_q_reg;
                    cur_lvl_reg         <= work_lvl_reg;
                    if (nxt_ok)
                    begin
                        status_reg[nxt_idx] <= ST_RUNNING;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the multilevel feedback queue scheduler top level.
`timescale 1ns / 100ps

// The testbench sends scheduling events on the req channel and checks every
// result beat on the rsp channel. Expected results come from a predictor that
// keeps its own copy of the per-level queues, the thread status table, the
// current level, the live-thread count and the running thread.
//
// Stimulus comes in two parts. A short directed table runs first. Its early
// rows, right after reset, carry results that are typed in by hand. Every
// later row is checked against the predictor. A long random part follows. It
// is built mostly from well-formed traffic: timer ticks and block or end
// events aimed at the running thread, and unblock events aimed at blocked
// threads. It also mixes in floods of new threads, which fill level 0 and
// push the live count to its ceiling. Floods of end events drain the live
// count to zero and leave the scheduler idle. Storms of timer ticks push
// threads down to the bottom level. A small share of the events is noise
// with random codes, unused codes among them.
//
// The sender works in bursts with random gaps. The receiver cycles through
// open, random and fixed stall patterns. Once, it holds off for a long
// stretch so that the result register fills and the input stalls.
module tb;
    import mfqs_pkg::*;

    localparam int NUM_THREADS  = 16;
    localparam int NUM_LEVELS   = 16;
    localparam int RANDOM_ITEMS = 1500;
    localparam int SEGMENT_LEN  = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int QUIET_LIMIT  = 4000;

    // These event codes are not in the package. The block must ignore them.
    localparam logic [2:0] FUNC_RSVD5 = 3'd5;
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    typedef enum {MIX_NORMAL, MIX_NEW_FLOOD, MIX_END_FLOOD, MIX_TIMER_STORM} mix_t;
    typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

    typedef struct {
        req_t beat;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    multilevel_feedback_queue_scheduler_top #(
        .NUM_THREADS(NUM_THREADS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always #1 clk = ~clk;

    // This is the scheduler state as the predictor sees it.
    logic [TID_W-1:0] lvl_store [NUM_LEVELS][NUM_THREADS];
    int               lvl_head  [NUM_LEVELS];
    int               lvl_tail  [NUM_LEVELS];
    int               lvl_cnt   [NUM_LEVELS];
    status_t          thr_status[NUM_THREADS];
    int               cur_lvl;
    int               live_cnt;
    logic [TID_W-1:0] run_tid;

    rsp_t     expected_rsp_q[$];
    dir_row_t dir_tbl[$];
    int       err_cnt    = 0;
    int       rsp_seen   = 0;
    int       burst_left = 0;
    int       quiet_cnt  = 0;

    task automatic sched_reset();
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            lvl_head[l] = 0;
            lvl_tail[l] = 0;
            lvl_cnt[l]  = 0;
            for (int s = 0; s < NUM_THREADS; s++)
                lvl_store[l][s] = '0;
        end
        for (int t = 0; t < NUM_THREADS; t++)
            thr_status[t] = ST_READY;
        cur_lvl  = 0;
        live_cnt = 1;
        run_tid  = '0;
    endtask

    // If the level is already full, the push is dropped without a word.
    function automatic void level_push(int lvl, logic [TID_W-1:0] tid);
        if (lvl_cnt[lvl] < NUM_THREADS)
        begin
            lvl_store[lvl][lvl_tail[lvl]] = tid;
            lvl_tail[lvl] = (lvl_tail[lvl] + 1) % NUM_THREADS;
            lvl_cnt[lvl]++;
        end
    endfunction

    // The demotion target is one level below the current one. The bottom level
    // never demotes. A preempted thread that is the only live one stays put.
    function automatic int demote_target(bit stay);
        if (stay || cur_lvl >= NUM_LEVELS - 1)
            return cur_lvl;
        return cur_lvl + 1;
    endfunction

    // This function applies one event to the predicted state and returns the
    // result beat that the event should produce.
    function automatic rsp_t sched_predict(req_t beat);
        rsp_t             res;
        bit               need_sw;
        bit               found;
        int               tid;
        logic [TID_W-1:0] nxt;
        res = '0;
        need_sw = 1'b0;
        found = 1'b0;
        tid = int'(beat.thread_id);
        res.old_thread = run_tid;
        case (beat.func)
            FUNC_NEW:
            begin
                thr_status[tid] = ST_READY;
                level_push(0, beat.thread_id);
                if (live_cnt < LIVE_MAX)
                    live_cnt++;
            end
            FUNC_BLOCK:
            begin
                thr_status[tid] = ST_BLOCKED;
                need_sw = 1'b1;
            end
            FUNC_END:
            begin
                thr_status[tid] = ST_ENDED;
                need_sw = 1'b1;
                if (live_cnt > 0)
                    live_cnt--;
            end
            FUNC_UNBLOCK:
            begin
                thr_status[tid] = ST_READY;
                level_push(demote_target(1'b0), beat.thread_id);
            end
            FUNC_TIMER:
            begin
                // A tick only preempts the thread that is marked running.
                if (thr_status[tid] == ST_RUNNING)
                begin
                    thr_status[tid] = ST_READY;
                    level_push(demote_target(live_cnt == 1), beat.thread_id);
                    need_sw = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (need_sw)
        begin
            res.idle = 1'b1;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                if (!found && lvl_cnt[l] != 0)
                begin
                    found = 1'b1;
                    nxt = lvl_store[l][lvl_head[l]];
                    lvl_head[l] = (lvl_head[l] + 1) % NUM_THREADS;
                    lvl_cnt[l]--;
                    cur_lvl = l;
                    thr_status[nxt] = ST_RUNNING;
                    run_tid = nxt;
                    res.switched = 1'b1;
                    res.next_thread = nxt;
                    res.idle = 1'b0;
                end
            end
        end
        return res;
    endfunction

    task automatic add_row(logic [2:0] func, int tid, bit typed,
                           bit sw, int old, int nxt, bit idl);
        dir_row_t row;
        row.beat.func = func;
        row.beat.thread_id = TID_W'(tid);
        row.typed = typed;
        row.want.switched = sw;
        row.want.old_thread = TID_W'(old);
        row.want.next_thread = TID_W'(nxt);
        row.want.idle = idl;
        dir_tbl.push_back(row);
    endtask

    // This task offers one beat and holds it until it is accepted, then
    // records what the beat should produce. When a burst runs out, the sender
    // drops valid for a random gap before it offers the next beat. A gap of
    // zero keeps valid high across the two beats.
    task automatic drive_beat(req_t beat, bit typed, rsp_t typed_rsp);
        rsp_t pred;
        int   gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req <= beat;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pred = sched_predict(beat);
        expected_rsp_q.push_back(typed ? typed_rsp : pred);
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // This block checks each result beat against the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_seen++;
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, rsp);
                err_cnt++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                check_field("switched", int'(want.switched), int'(rsp.switched));
                check_field("old_thread", int'(want.old_thread), int'(rsp.old_thread));
                check_field("next_thread", int'(want.next_thread), int'(rsp.next_thread));
                check_field("idle", int'(want.idle), int'(rsp.idle));
            end
        end
    end

    // The watchdog ends the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cnt = 0;
        else
        begin
            quiet_cnt++;
            if (quiet_cnt >= QUIET_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // The receiver runs in stretches: fully open, random stalls, or a fixed
    // stall pattern. Once enough results have come back, it holds off for a
    // long stretch. The sender keeps offering beats during the hold.
    initial
    begin : rx_side
        rx_mode_t rx_mode;
        int       span;
        bit       held;
        held = 1'b0;
        rsp_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            span = $urandom_range(8, 64);
            for (int c = 0; c < span; c++)
            begin
                @(posedge clk);
                case (rx_mode)
                    RX_OPEN:   rsp_ready <= 1'b1;
                    RX_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
                    default:   rsp_ready <= (c % 3 != 2);
                endcase
            end
            if (!held && rsp_seen >= 400)
            begin
                held = 1'b1;
                @(posedge clk);
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        req_t beat;
        mix_t mix;
        int   pick;
        int   base;
        rst_n = 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        sched_reset();

        // The first rows run right after reset. A timer tick on a thread that
        // is only ready changes nothing. A block finds every level empty and
        // reports idle. Unused codes change nothing. New threads cause no
        // switch.
        add_row(FUNC_TIMER,   0,  1'b1, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_BLOCK,   0,  1'b1, 1'b0, 0, 0, 1'b1);
        add_row(FUNC_RSVD5,   15, 1'b1, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_RSVD6,   7,  1'b1, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_RSVD7,   0,  1'b1, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_NEW,     15, 1'b1, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_NEW,     0,  1'b1, 1'b0, 0, 0, 1'b0);
        // From here on, the predictor supplies the expected results. These
        // rows cover dispatch, demotion on preemption and unblock, a tick on
        // a thread that is not running, and the case where the only live
        // thread is preempted and stays at its level. They also cover the live
        // count saturating at zero while the scheduler is idle.
        add_row(FUNC_END,     0,  1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_TIMER,   15, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_TIMER,   0,  1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_TIMER,   3,  1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_UNBLOCK, 9,  1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_BLOCK,   15, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_END,     0,  1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_TIMER,   9,  1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_END,     9,  1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_END,     9,  1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_END,     10, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_NEW,     3,  1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_UNBLOCK, 15, 1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_BLOCK,   9,  1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_TIMER,   3,  1'b0, 1'b0, 0, 0, 1'b0);
        add_row(FUNC_RSVD7,   15, 1'b0, 1'b0, 0, 0, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tbl[i])
            drive_beat(dir_tbl[i].beat, dir_tbl[i].typed, dir_tbl[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % SEGMENT_LEN == 0)
            begin
                pick = $urandom_range(0, 9);
                mix = (pick < 6) ? MIX_NORMAL : (pick == 6) ? MIX_NEW_FLOOD :
                      (pick == 7) ? MIX_END_FLOOD : MIX_TIMER_STORM;
            end
            beat.thread_id = TID_W'($urandom_range(0, NUM_THREADS - 1));
            case (mix)
                MIX_NEW_FLOOD:   beat.func = FUNC_NEW;
                MIX_END_FLOOD:   beat.func = FUNC_END;
                MIX_TIMER_STORM:
                begin
                    beat.func = FUNC_TIMER;
                    beat.thread_id = run_tid;
                end
                default:
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35)
                    begin
                        beat.func = FUNC_TIMER;
                        beat.thread_id = run_tid;
                    end
                    else if (pick < 50)
                        beat.func = FUNC_NEW;
                    else if (pick < 60)
                    begin
                        beat.func = FUNC_BLOCK;
                        if ($urandom_range(0, 4) != 0)
                            beat.thread_id = run_tid;
                    end
                    else if (pick < 68)
                    begin
                        beat.func = FUNC_END;
                        beat.thread_id = run_tid;
                    end
                    else if (pick < 82)
                    begin
                        // Wake a blocked thread if one exists.
                        beat.func = FUNC_UNBLOCK;
                        base = $urandom_range(0, NUM_THREADS - 1);
                        for (int j = 0; j < NUM_THREADS; j++)
                            if (thr_status[(base + j) % NUM_THREADS] == ST_BLOCKED)
                                beat.thread_id = TID_W'((base + j) % NUM_THREADS);
                    end
                    else if (pick < 90)
                        beat.func = FUNC_TIMER;
                    else
                        beat.func = 3'($urandom_range(0, int'(FUNC_RSVD7)));
                end
            endcase
            drive_beat(beat, 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0 && expected_rsp_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/mfqs_pkg.sv
rtl/core/multilevel_feedback_queue_scheduler_top.sv
dv/tb.sv
